// ===== rtl/core/humidity_pressure_temp_compensation_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the compensation pipeline
// Implication helpers with a common clock and reset guard.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// Same-cycle implication.
`define HPTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hptc_pkg.sv =====
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared types, register indexes and wrapping multiply helpers.
// ----------------------------------------------------------------------------
package hptc_pkg;

  localparam int DIV_STEPS = 64;

  localparam logic [2:0] CFG_IDX_TEMP   = 3'd0;
  localparam logic [2:0] CFG_IDX_PRESSA = 3'd1;
  localparam logic [2:0] CFG_IDX_PRESSB = 3'd2;
  localparam logic [2:0] CFG_IDX_P9HUMA = 3'd3;
  localparam logic [2:0] CFG_IDX_HUMB   = 3'd4;

  localparam logic [31:0] HUM_CLAMP = 32'd419430400;

  // Data that rides beside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        den_zero;
    logic        quot_neg;
  } hptc_side_t;

  // Partial products of a 64x64 multiply, low 64 bits kept.
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid;
  } hptc_pp_t;

  function automatic logic [31:0] sx32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // x times a signed 17-bit coefficient, wrapping at 64 bits.
  function automatic logic [63:0] mul_w16(input logic [63:0] x, input logic [16:0] c);
    logic signed [64:0] prod;
    logic [31:0]        cx;
    logic [31:0]        hi;
    cx   = {{15{c[16]}}, c};
    prod = $signed({1'b0, x[31:0]}) * $signed(cx);
    hi   = x[63:32] * cx;
    return prod[63:0] + {hi, 32'd0};
  endfunction

  function automatic hptc_pp_t mul_pp(input logic [63:0] x, input logic [63:0] y);
    hptc_pp_t r;
    r.lo  = 64'(x[31:0]) * 64'(y[31:0]);
    r.mid = x[31:0] * y[63:32] + x[63:32] * y[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input hptc_pp_t p);
    return p.lo + {p.mid, 32'd0};
  endfunction

endpackage

// ===== rtl/core/hptc_div.sv =====
// ----------------------------------------------------------------------------
// hptc_div
// Pipelined unsigned 64/64 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hptc_div
  import hptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  hptc_side_t  side_i,
  output logic        valid_o,
  output logic [63:0] quot_o,
  output hptc_side_t  side_o
);

  logic [63:0]          rem_q  [DIV_STEPS];
  logic [63:0]          num_q  [DIV_STEPS];
  logic [63:0]          den_q  [DIV_STEPS];
  hptc_side_t           side_q [DIV_STEPS];
  logic                 vld_q  [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] num_in;
    logic [63:0] den_in;
    hptc_side_t  side_in;
    logic        vld_in;
    logic [64:0] trial;
    logic        fits;
    logic [63:0] rem_d;
    logic [63:0] num_d;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign num_in  = num_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // Bring down the next dividend bit, subtract when the divisor fits.
    assign trial = {rem_in, num_in[63]};
    assign fits  = trial >= {1'b0, den_in};
    assign rem_d = fits ? 64'(trial - {1'b0, den_in}) : trial[63:0];
    assign num_d = {num_in[62:0], fits};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= rem_d;
        num_q[i]  <= num_d;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quot_o  = num_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

// ===== rtl/core/humidity_pressure_temp_compensation.sv =====
// Throughput: one beat per cycle while the output beat is not stalled.
// Depth is set by the 64-stage pressure divider plus the arithmetic stages around it.
// All stages advance together; a stalled output beat freezes the whole pipe.
// Reset clears valid bits and coefficient registers (all coefficients read as zero).
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation
// Fixed-point compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation
  import hptc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [19:0]        adc_temp_i,
  input  logic [19:0]        adc_press_i,
  input  logic [15:0]        adc_hum_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic [16:0]        humidity_q22_10_o
);

`include "humidity_pressure_temp_compensation_macros.svh"

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_coeffs_q;
  logic [63:0] press_a_q;
  logic [63:0] press_b_q;
  logic [47:0] p9_hum_a_q;
  logic [39:0] hum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      p9_hum_a_q    <= '0;
      hum_b_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_TEMP:   temp_coeffs_q <= cfg_wdata_i[47:0];
        CFG_IDX_PRESSA: press_a_q     <= cfg_wdata_i;
        CFG_IDX_PRESSB: press_b_q     <= cfg_wdata_i;
        CFG_IDX_P9HUMA: p9_hum_a_q    <= cfg_wdata_i[47:0];
        CFG_IDX_HUMB:   hum_b_q       <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic [7:0]  h1, h3, h6;

  assign t1 = temp_coeffs_q[15:0];
  assign t2 = temp_coeffs_q[31:16];
  assign t3 = temp_coeffs_q[47:32];
  assign p1 = press_a_q[15:0];
  assign p2 = press_a_q[31:16];
  assign p3 = press_a_q[47:32];
  assign p4 = press_a_q[63:48];
  assign p5 = press_b_q[15:0];
  assign p6 = press_b_q[31:16];
  assign p7 = press_b_q[47:32];
  assign p8 = press_b_q[63:48];
  assign p9 = p9_hum_a_q[15:0];
  assign h1 = p9_hum_a_q[23:16];
  assign h2 = p9_hum_a_q[39:24];
  assign h3 = p9_hum_a_q[47:40];
  assign h4 = hum_b_q[15:0];
  assign h5 = hum_b_q[31:16];
  assign h6 = hum_b_q[39:32];

  // --------------------------------------------------------------------------
  // Flow control: every stage advances when the output beat is free or taken
  // --------------------------------------------------------------------------
  logic        adv;
  logic [12:1] vld_q;
  logic        out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Carried inputs and temperature result (shift lines)
  logic [19:0] adcp_q [1:8];
  logic [15:0] adch_q [1:4];
  logic [31:0] temp_q [4:11];

  // Stage 1-3: temperature and fine temperature
  logic [31:0] t_x1, t_dd_base;
  logic [31:0] t_m1_d, t_m1_q, t_dd_d, t_dd_q;
  logic [31:0] t_v1_d, t_v1_q, t_m3_d, t_m3_q;
  logic [31:0] tf_d, tf_q;

  assign t_x1      = {15'd0, adc_temp_i[19:3]} - {15'd0, t1, 1'b0};
  assign t_dd_base = {16'd0, adc_temp_i[19:4]} - {16'd0, t1};
  assign t_m1_d    = t_x1 * sx32(t2);
  assign t_dd_d    = t_dd_base * t_dd_base;
  assign t_v1_d    = 32'($signed(t_m1_q) >>> 11);
  assign t_m3_d    = 32'($signed(t_dd_q) >>> 12) * sx32(t3);
  assign tf_d      = t_v1_q + 32'($signed(t_m3_q) >>> 14);

  // Stage 4: centi-degrees, pressure and humidity offsets
  logic [31:0] temp_d, tf5;
  logic [63:0] pa4_d, pa4_q;
  logic [31:0] hv4_d, hv4_q;

  assign tf5    = tf_q * 32'd5 + 32'd128;
  assign temp_d = 32'($signed(tf5) >>> 8);
  assign pa4_d  = {{32{tf_q[31]}}, tf_q} - 64'd128000;
  assign hv4_d  = tf_q - 32'd76800;

  // Pressure stages 5-11
  hptc_pp_t    aa5_d, aa5_q;
  logic [63:0] ap5_5_d, ap5_5_q, ap2_5_d, ap2_5_q;
  logic [63:0] aa6_d, aa6_q, ap5_6_q, ap2_6_q;
  logic [63:0] b1_7_d, b1_7_q, c1_7_d, c1_7_q, ap5_7_q, ap2_7_q;
  logic [63:0] b8_d, b8_q, a2_8_d, a2_8_q;
  logic [63:0] pv, s9_d, s9_q, n0_9_d, n0_9_q;
  logic [63:0] a3_10_d, a3_10_q, n1_10_d, n1_10_q;
  logic [63:0] den11_d, den11_q, num11_q;

  assign aa5_d   = mul_pp(pa4_q, pa4_q);
  assign ap5_5_d = mul_w16(pa4_q, {p5[15], p5});
  assign ap2_5_d = mul_w16(pa4_q, {p2[15], p2});
  assign aa6_d   = pp_sum(aa5_q);
  assign b1_7_d  = mul_w16(aa6_q, {p6[15], p6});
  assign c1_7_d  = mul_w16(aa6_q, {p3[15], p3});
  assign b8_d    = b1_7_q + (ap5_7_q << 17) + (sx64(p4) << 35);
  assign a2_8_d  = 64'($signed(c1_7_q) >>> 8) + (ap2_7_q << 12);
  assign s9_d    = 64'h0000_8000_0000_0000 + a2_8_q;
  assign pv      = 64'd1048576 - {44'd0, adcp_q[8]};
  assign n0_9_d  = (pv << 31) - b8_q;
  assign a3_10_d = mul_w16(s9_q, {1'b0, p1});
  assign n1_10_d = mul_w16(n0_9_q, 17'd3125);
  assign den11_d = 64'($signed(a3_10_q) >>> 33);

  // Humidity stages 5-11
  logic [31:0] x0_5_d, x0_5_q, hm5_d, hm5_q, vh6_5_d, vh6_5_q, vh3_5_d, vh3_5_q;
  logic [31:0] x6_sum, x6_d, x6_q, y0_6_d, y0_6_q, y1_6_d, y1_6_q;
  logic [31:0] x7_q, y2_7_d, y2_7_q;
  logic [31:0] y3, x8_q, y4_8_d, y4_8_q;
  logic [31:0] y5, v2_9_d, v2_9_q;
  logic [31:0] s10, v2_10_q, ss10_d, ss10_q;
  logic [31:0] w11, v3, vc;
  logic [16:0] hum11_d, hum11_q;

  assign x0_5_d  = ({16'd0, adch_q[4]} << 14) - (sx32(h4) << 20);
  assign hm5_d   = sx32(h5) * hv4_q;
  assign vh6_5_d = hv4_q * {{24{h6[7]}}, h6};
  assign vh3_5_d = hv4_q * {24'd0, h3};
  assign x6_sum  = x0_5_q - hm5_q + 32'd16384;
  assign x6_d    = 32'($signed(x6_sum) >>> 15);
  assign y0_6_d  = 32'($signed(vh6_5_q) >>> 10);
  assign y1_6_d  = 32'($signed(vh3_5_q) >>> 11) + 32'd32768;
  assign y2_7_d  = y0_6_q * y1_6_q;
  assign y3      = 32'($signed(y2_7_q) >>> 10) + 32'd2097152;
  assign y4_8_d  = y3 * sx32(h2);
  assign y5      = 32'($signed(y4_8_q + 32'd8192) >>> 14);
  assign v2_9_d  = x8_q * y5;
  assign s10     = 32'($signed(v2_9_q) >>> 15);
  assign ss10_d  = s10 * s10;
  assign w11     = 32'($signed(ss10_q) >>> 7) * {24'd0, h1};
  assign v3      = v2_10_q - 32'($signed(w11) >>> 4);

  // Clamp to the valid percent range before dropping the fraction bits.
  always_comb begin
    if (v3[31]) begin
      vc = '0;
    end else if (v3 > HUM_CLAMP) begin
      vc = HUM_CLAMP;
    end else begin
      vc = v3;
    end
  end
  assign hum11_d = vc[28:12];

  // Stage 12: magnitudes and signs for the divider
  logic [63:0] dnum12_d, dnum12_q, dden12_d, dden12_q;
  hptc_side_t  side12_d, side12_q;

  assign dnum12_d          = num11_q[63] ? 64'd0 - num11_q : num11_q;
  assign dden12_d          = den11_q[63] ? 64'd0 - den11_q : den11_q;
  assign side12_d.temp     = temp_q[11];
  assign side12_d.hum      = hum11_q;
  assign side12_d.den_zero = den11_q == 64'd0;
  assign side12_d.quot_neg = num11_q[63] ^ den11_q[63];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[11:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adcp_q[1] <= adc_press_i;
      for (int i = 2; i <= 8; i++) begin
        adcp_q[i] <= adcp_q[i-1];
      end
      adch_q[1] <= adc_hum_i;
      for (int i = 2; i <= 4; i++) begin
        adch_q[i] <= adch_q[i-1];
      end
      temp_q[4] <= temp_d;
      for (int i = 5; i <= 11; i++) begin
        temp_q[i] <= temp_q[i-1];
      end
      t_m1_q   <= t_m1_d;
      t_dd_q   <= t_dd_d;
      t_v1_q   <= t_v1_d;
      t_m3_q   <= t_m3_d;
      tf_q     <= tf_d;
      pa4_q    <= pa4_d;
      hv4_q    <= hv4_d;
      aa5_q    <= aa5_d;
      ap5_5_q  <= ap5_5_d;
      ap2_5_q  <= ap2_5_d;
      aa6_q    <= aa6_d;
      ap5_6_q  <= ap5_5_q;
      ap2_6_q  <= ap2_5_q;
      b1_7_q   <= b1_7_d;
      c1_7_q   <= c1_7_d;
      ap5_7_q  <= ap5_6_q;
      ap2_7_q  <= ap2_6_q;
      b8_q     <= b8_d;
      a2_8_q   <= a2_8_d;
      s9_q     <= s9_d;
      n0_9_q   <= n0_9_d;
      a3_10_q  <= a3_10_d;
      n1_10_q  <= n1_10_d;
      den11_q  <= den11_d;
      num11_q  <= n1_10_q;
      x0_5_q   <= x0_5_d;
      hm5_q    <= hm5_d;
      vh6_5_q  <= vh6_5_d;
      vh3_5_q  <= vh3_5_d;
      x6_q     <= x6_d;
      y0_6_q   <= y0_6_d;
      y1_6_q   <= y1_6_d;
      x7_q     <= x6_q;
      y2_7_q   <= y2_7_d;
      x8_q     <= x7_q;
      y4_8_q   <= y4_8_d;
      v2_9_q   <= v2_9_d;
      v2_10_q  <= v2_9_q;
      ss10_q   <= ss10_d;
      hum11_q  <= hum11_d;
      dnum12_q <= dnum12_d;
      dden12_q <= dden12_d;
      side12_q <= side12_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  logic        div_vld;
  logic [63:0] div_quot;
  hptc_side_t  div_side;

  hptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vld_q[12]),
    .num_i   (dnum12_q),
    .den_i   (dden12_q),
    .side_i  (side12_q),
    .valid_o (div_vld),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // --------------------------------------------------------------------------
  // Post-divide pressure correction and output beat
  // --------------------------------------------------------------------------
  logic        pa_vld_q, pb_vld_q, pc_vld_q, pd_vld_q;
  logic [63:0] pa_p_d, pa_p_q;
  hptc_side_t  pa_side_q, pb_side_q, pc_side_q, pd_side_q;
  logic [63:0] ps;
  logic [63:0] pb_t1_d, pb_t1_q, pb_ps_q, pb_bb_d, pb_bb_q, pb_p_q;
  hptc_pp_t    pc_pp_d, pc_pp_q;
  logic [63:0] pc_bb_q, pc_p_q;
  logic [63:0] pd_t2_d, pd_t2_q, pd_bb_q, pd_p_q;
  logic [63:0] press_sum, press;

  assign pa_p_d    = div_side.quot_neg ? 64'd0 - div_quot : div_quot;
  assign ps        = 64'($signed(pa_p_q) >>> 13);
  assign pb_t1_d   = mul_w16(ps, {p9[15], p9});
  assign pb_bb_d   = mul_w16(pa_p_q, {p8[15], p8});
  assign pc_pp_d   = mul_pp(pb_t1_q, pb_ps_q);
  assign pd_t2_d   = pp_sum(pc_pp_q);
  assign press_sum = pd_p_q + 64'($signed(pd_t2_q) >>> 25) + 64'($signed(pd_bb_q) >>> 19);
  // Drop the result when the divisor was zero.
  assign press     = pd_side_q.den_zero ? 64'd0
                   : 64'($signed(press_sum) >>> 8) + (sx64(p7) << 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q  <= 1'b0;
      pb_vld_q  <= 1'b0;
      pc_vld_q  <= 1'b0;
      pd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      pa_vld_q  <= div_vld;
      pb_vld_q  <= pa_vld_q;
      pc_vld_q  <= pb_vld_q;
      pd_vld_q  <= pc_vld_q;
      out_vld_q <= pd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_p_q              <= pa_p_d;
      pa_side_q           <= div_side;
      pb_t1_q             <= pb_t1_d;
      pb_ps_q             <= ps;
      pb_bb_q             <= pb_bb_d;
      pb_p_q              <= pa_p_q;
      pb_side_q           <= pa_side_q;
      pc_pp_q             <= pc_pp_d;
      pc_bb_q             <= pb_bb_q;
      pc_p_q              <= pb_p_q;
      pc_side_q           <= pb_side_q;
      pd_t2_q             <= pd_t2_d;
      pd_bb_q             <= pc_bb_q;
      pd_p_q              <= pc_p_q;
      pd_side_q           <= pc_side_q;
      temperature_centi_o <= $signed(pd_side_q.temp);
      pressure_q24_8_o    <= press[31:0];
      humidity_q22_10_o   <= pd_side_q.hum;
    end
  end

  assign out_valid_o = out_vld_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HPTC_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[1], "accepted beat did not enter stage one")
  `HPTC_ASSERT_NXT(a_div_holds, clk_i, rst_ni, !adv, $stable(div_vld), "divider moved during a stall")
  `HPTC_ASSERT_IMP(a_hum_range, clk_i, rst_ni, out_valid_o, humidity_q22_10_o <= 17'd102400, "humidity beyond clamp")

endmodule
